/* sv/assert_macros.svh */
// Assertion macros used by the top-level RTL file of the pair cutoff matrix builder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("assertion failed");

// Checks that a condition implies another in the same cycle.
`define ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Checks that a condition implies another in the following cycle.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* sv/pcidm_pkg.sv */
// Shared types and constants of the pair cutoff inverse distance matrix builder.
package pcidm_pkg;

   localparam int COORD_BITS      = 24;
   localparam int ATOM_INDEX_BITS = 20;
   localparam int MATRIX_SLOTS    = 65536;

   localparam int DIST_BITS  = 2 * (COORD_BITS + 1);
   localparam int VALUE_BITS = 32;
   localparam int FILL_BITS  = 17;
   localparam int CUT_BITS   = 50;
   localparam int GROUP_BITS = 32;

   localparam int REQ_TDATA_W = 216;
   localparam int RSP_TDATA_W = 128;

   localparam logic [CUT_BITS-1:0]   CUTOFF_RESET   = 50'd1677721600;
   localparam logic [GROUP_BITS-1:0] GROUP_RESET    = 32'd1;
   localparam logic [FILL_BITS-1:0]  CAPACITY_RESET = 17'd65536;

   // At or below this squared distance the value saturates.
   localparam logic [DIST_BITS-1:0]  D2_SAT_LIMIT = 50'd64;
   localparam logic [VALUE_BITS-1:0] VALUE_SAT    = 32'hFFFF_FFFF;

   localparam logic REC_ENTRY   = 1'b0;
   localparam logic REC_SUMMARY = 1'b1;

   typedef enum logic [1:0] {
      CSR_CUTOFF   = 2'd0,
      CSR_GROUP    = 2'd1,
      CSR_CAPACITY = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic                  done;
      logic [VALUE_BITS-1:0] value;
   } recip_rsp_type;

endpackage

/* sv/pcidm_recip.sv */
// Iterative unit: floor(sqrt(floor(2^70 / d2))) by restoring division then a root recurrence.
module pcidm_recip (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [pcidm_pkg::DIST_BITS-1:0]     d2,
   output pcidm_pkg::recip_rsp_type            rsp
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIV,
      S_SQRT
   } state_type;

   state_type                           state_ff, state_in;
   logic [5:0]                          cnt_ff, cnt_in;
   logic [pcidm_pkg::DIST_BITS-1:0]     d2_ff, d2_in;
   logic [49:0]                         rem_ff, rem_in;
   logic [63:0]                         quot_ff, quot_in;
   logic [31:0]                         root_ff, root_in;
   logic                                done_ff, done_in;

   logic [51:0] op_a;
   logic [51:0] op_b;
   logic [52:0] diff;
   logic        ge;

   // One shared subtractor serves both the division and the root steps.
   always_comb begin
      if (state_ff == S_DIV) begin
         op_a = {1'b0, rem_ff, 1'b0};
         op_b = {2'b00, d2_ff};
      end else begin
         op_a = {17'd0, rem_ff[32:0], quot_ff[63:62]};
         op_b = {18'd0, root_ff, 2'b01};
      end
      diff = {1'b0, op_a} - {1'b0, op_b};
      ge   = ~diff[52];
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      d2_in    = d2_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      root_in  = root_ff;
      done_in  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               d2_in    = d2;
               // The leading quotient bits are zero; the remainder has reached 64.
               rem_in   = 50'd64;
               quot_in  = 64'd0;
               cnt_in   = 6'd63;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            rem_in  = ge ? diff[49:0] : op_a[49:0];
            quot_in = {quot_ff[62:0], ge};
            cnt_in  = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) begin
               rem_in   = 50'd0;
               root_in  = 32'd0;
               cnt_in   = 6'd31;
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            rem_in  = {17'd0, (ge ? diff[32:0] : op_a[32:0])};
            root_in = {root_ff[30:0], ge};
            quot_in = {quot_ff[61:0], 2'b00};
            cnt_in  = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) begin
               done_in  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      d2_ff   <= d2_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      root_ff <= root_in;
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   assign rsp.done  = done_ff;
   assign rsp.value = root_ff;

endmodule

/* sv/pair_cutoff_inverse_distance_matrix.sv */
// Top level of the pair cutoff inverse distance matrix builder.
// Usage:
// Neighbor pair items enter on the req_ channel, grouped in rows closed by req_tlast.
// Records leave on the rsp_ channel: an entry record for each stored pair inside the
// cutoff, and a summary record (first slot, count) on a selected item that closes a row.
// Registers are written on the csr_ channel, which is always ready; write only while idle.
// Flow: an item is taken only in the idle state. A stored pair sums the squares of its
// three axis differences in the shared squarer, then, unless its value saturates, goes
// through 64 division steps and 32 root steps in the shared subtractor of the
// reciprocal unit before its entry record. When the item closes a row, a summary
// record follows the entry record.
// The last record of an item waits in the output register while the next item is
// worked on; when the receiver stalls, the block holds before loading a further record.
// Reset (synchronous, active high) restores the register defaults and clears the fill
// count, the open row and the overflow flag; the block is ready in the next cycle.
`include "assert_macros.svh"

module pair_cutoff_inverse_distance_matrix #(
   parameter int MATRIX_SLOTS = pcidm_pkg::MATRIX_SLOTS
) (
   input  logic                                clock,
   input  logic                                reset,
   // row_index, atom_groups, xi, yi, zi, xj, yj, zj, neighbor_index
   input  logic [pcidm_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // pass_start, has_pair
   input  logic [1:0]                          req_tuser,
   input  logic                                req_tlast,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // slot, column, value, row_id, row_first, row_count, overflow, zero fill
   output logic [pcidm_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // record_kind
   output logic                                rsp_tuser,
   output logic                                rsp_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [1:0]                          csr_index,
   input  logic [pcidm_pkg::CUT_BITS-1:0]      csr_data
);

   localparam int FW = pcidm_pkg::FILL_BITS;
   localparam int DW = pcidm_pkg::DIST_BITS;
   localparam int MW = pcidm_pkg::COORD_BITS + 1;
   localparam int AW = pcidm_pkg::ATOM_INDEX_BITS;
   localparam logic [FW-1:0] SLOT_LIMIT =
      FW'((MATRIX_SLOTS > (2 ** FW) - 1) ? (2 ** FW) - 1 : MATRIX_SLOTS);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SQUARE,
      S_CHECK,
      S_RECIP,
      S_ENTRY,
      S_SUMMARY
   } state_type;

   state_type                              state_ff, state_in;
   logic [pcidm_pkg::CUT_BITS-1:0]         cutoff_ff, cutoff_in;
   logic [pcidm_pkg::GROUP_BITS-1:0]       group_ff, group_in;
   logic [FW-1:0]                          capacity_ff, capacity_in;
   logic [FW-1:0]                          fill_ff, fill_in;
   logic [FW-1:0]                          row_first_ff, row_first_in;
   logic                                   in_row_ff, in_row_in;
   logic                                   ovf_ff, ovf_in;

   logic [AW-1:0]                          row_id_ff, row_id_in;
   logic [AW-1:0]                          column_ff, column_in;
   logic                                   row_end_ff, row_end_in;
   logic [MW-1:0]                          mag_ff [3];
   logic [MW-1:0]                          mag_in [3];
   logic [1:0]                             sq_cnt_ff, sq_cnt_in;
   logic [DW-1:0]                          d2_ff, d2_in;
   logic [pcidm_pkg::VALUE_BITS-1:0]       value_ff, value_in;

   logic                                   rsp_valid_ff, rsp_valid_in;
   logic                                   rsp_kind_ff, rsp_kind_in;
   logic                                   rsp_last_ff, rsp_last_in;
   logic [pcidm_pkg::RSP_TDATA_W-1:0]      rsp_data_ff, rsp_data_in;

   logic                                   req_accept;
   logic                                   out_free;
   logic                                   recip_start;
   pcidm_pkg::recip_rsp_type               recip_rsp;
   logic [FW-1:0]                          cap;
   logic [FW-1:0]                          fill_next;
   logic [MW-1:0]                          mag_sel;
   logic [DW-1:0]                          sq;
   logic                                   selected;
   logic                                   pass_start;
   logic                                   has_pair;
   logic [FW-1:0]                          fill_eff;
   logic                                   in_row_eff;
   logic signed [MW-1:0]                   coord_diff [3];

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign cap       = (capacity_ff < SLOT_LIMIT) ? capacity_ff : SLOT_LIMIT;
   assign fill_next = fill_ff + FW'(1);

   assign pass_start = req_tuser[0];
   assign has_pair   = req_tuser[1];
   assign selected   = |(req_tdata[51:20] & group_ff);
   assign fill_eff   = pass_start ? '0 : fill_ff;
   assign in_row_eff = pass_start ? 1'b0 : in_row_ff;

   // Neighbor minus row atom for each axis, then the magnitude.
   always_comb begin
      coord_diff[0] = $signed({req_tdata[147], req_tdata[147:124]})
                    - $signed({req_tdata[75], req_tdata[75:52]});
      coord_diff[1] = $signed({req_tdata[171], req_tdata[171:148]})
                    - $signed({req_tdata[99], req_tdata[99:76]});
      coord_diff[2] = $signed({req_tdata[195], req_tdata[195:172]})
                    - $signed({req_tdata[123], req_tdata[123:100]});
   end

   assign mag_sel = mag_ff[sq_cnt_ff];
   assign sq      = DW'(mag_sel) * DW'(mag_sel);

   always_comb begin
      cutoff_in    = cutoff_ff;
      group_in     = group_ff;
      capacity_in  = capacity_ff;
      if (csr_valid && csr_ready) begin
         case (pcidm_pkg::csr_index_type'(csr_index))
            pcidm_pkg::CSR_CUTOFF:   cutoff_in   = csr_data;
            pcidm_pkg::CSR_GROUP:    group_in    = csr_data[31:0];
            pcidm_pkg::CSR_CAPACITY: capacity_in = csr_data[FW-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      row_first_in = row_first_ff;
      in_row_in    = in_row_ff;
      ovf_in       = ovf_ff;
      row_id_in    = row_id_ff;
      column_in    = column_ff;
      row_end_in   = row_end_ff;
      for (int k = 0; k < 3; k++) begin
         mag_in[k] = mag_ff[k];
      end
      sq_cnt_in    = sq_cnt_ff;
      d2_in        = d2_ff;
      value_in     = value_ff;
      recip_start  = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               row_id_in  = req_tdata[19:0];
               column_in  = req_tdata[215:196];
               row_end_in = req_tlast;
               for (int k = 0; k < 3; k++) begin
                  mag_in[k] = coord_diff[k][MW-1] ? MW'(-coord_diff[k]) : MW'(coord_diff[k]);
               end
               sq_cnt_in = 2'd0;
               d2_in     = '0;
               fill_in   = fill_eff;
               in_row_in = in_row_eff;
               if (pass_start) begin
                  ovf_in = 1'b0;
               end
               if (selected) begin
                  if (!in_row_eff) begin
                     row_first_in = fill_eff;
                     in_row_in    = 1'b1;
                  end
                  if (has_pair) begin
                     state_in = S_SQUARE;
                  end else if (req_tlast) begin
                     state_in = S_SUMMARY;
                  end
               end
            end
         end
         S_SQUARE: begin
            d2_in     = d2_ff + sq;
            sq_cnt_in = sq_cnt_ff + 2'd1;
            if (sq_cnt_ff == 2'd2) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if ((d2_ff <= cutoff_ff) && (fill_ff < cap)) begin
               if (d2_ff <= pcidm_pkg::D2_SAT_LIMIT) begin
                  value_in = pcidm_pkg::VALUE_SAT;
                  state_in = S_ENTRY;
               end else begin
                  recip_start = 1'b1;
                  state_in    = S_RECIP;
               end
            end else begin
               // A kept pair with no room left marks the store as full.
               if (d2_ff <= cutoff_ff) begin
                  ovf_in = 1'b1;
               end
               state_in = row_end_ff ? S_SUMMARY : S_IDLE;
            end
         end
         S_RECIP: begin
            if (recip_rsp.done) begin
               value_in = recip_rsp.value;
               state_in = S_ENTRY;
            end
         end
         S_ENTRY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = pcidm_pkg::REC_ENTRY;
               rsp_last_in  = !row_end_ff;
               rsp_data_in  = {5'd0, (ovf_ff || (fill_next >= cap)), 17'd0, 17'd0,
                               row_id_ff, value_ff, column_ff, fill_ff[15:0]};
               fill_in      = fill_next;
               ovf_in       = ovf_ff || (fill_next >= cap);
               state_in     = row_end_ff ? S_SUMMARY : S_IDLE;
            end
         end
         S_SUMMARY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = pcidm_pkg::REC_SUMMARY;
               rsp_last_in  = 1'b1;
               rsp_data_in  = {5'd0, ovf_ff, (fill_ff - row_first_ff), row_first_ff,
                               row_id_ff, 32'd0, 20'd0, 16'd0};
               in_row_in    = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      row_id_ff   <= row_id_in;
      column_ff   <= column_in;
      row_end_ff  <= row_end_in;
      mag_ff      <= mag_in;
      sq_cnt_ff   <= sq_cnt_in;
      d2_ff       <= d2_in;
      value_ff    <= value_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         cutoff_ff    <= pcidm_pkg::CUTOFF_RESET;
         group_ff     <= pcidm_pkg::GROUP_RESET;
         capacity_ff  <= pcidm_pkg::CAPACITY_RESET;
         fill_ff      <= '0;
         row_first_ff <= '0;
         in_row_ff    <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cutoff_ff    <= cutoff_in;
         group_ff     <= group_in;
         capacity_ff  <= capacity_in;
         fill_ff      <= fill_in;
         row_first_ff <= row_first_in;
         in_row_ff    <= in_row_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   pcidm_recip u_recip (
      .clock (clock),
      .reset (reset),
      .start (recip_start),
      .d2    (d2_ff),
      .rsp   (recip_rsp)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = rsp_data_ff;

   `ASSERT_IMPLY(a_recip_done_while_waiting, recip_rsp.done, state_ff == S_RECIP)
   `ASSERT_NEXT(a_summary_closes_row, (state_ff == S_SUMMARY) && out_free, !in_row_ff)
   `ASSERT_ALWAYS(a_row_first_within_fill, !in_row_ff || (row_first_ff <= fill_ff))

endmodule
